// File: hdl/lfutb_pkg.sv
// lfutb_pkg: shared types for the lfu replacement block with lru tie-break
// holds the operation codes carried on the input channel; no dependencies
package lfutb_pkg;

  typedef enum logic [1:0] {
    OP_INVALIDATE = 2'd0,
    OP_TOUCH      = 2'd1,
    OP_INSERT     = 2'd2,
    OP_VICTIM     = 2'd3
  } op_t;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned WAY_FLD_W = 3;
  localparam int unsigned NOW_W     = 32;

endpackage

// File: hdl/lfu_lru_tiebreak_replacement.sv
// lfu_lru_tiebreak_replacement: lfu replacement state for one cache set, lru tie-break
// per-way count and time stamp in one memory, victim search by one shared comparator
// depends on lfutb_pkg
// invalidate and insert pass S_RES, touch passes S_TOUCH then S_RES, victim search
//   runs S_SCAN then S_RES to the result register; one transaction in flight at a time
// ready again once the result loads; S_RES waits for a free output before loading it,
//   and during a search the single read port feeds the comparator one way per cycle
// reset clears control state and the per-way valid bits; an invalid way reads as zero,
//   so no clearing sweep runs and the block is ready right after reset
module lfu_lru_tiebreak_replacement
  import lfutb_pkg::*;
#(
  parameter int unsigned WAYS       = 8,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // way [2:0], now [34:3], zero [39:35]
  input  logic [1:0]  in_tuser,   // operation [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // victim_way [2:0], zero [7:3]
  output logic        out_tuser   // victim_valid [0]
);

  localparam int unsigned IDX_W  = $clog2(WAYS);
  localparam int unsigned WORD_W = TIME_BITS + COUNT_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOUCH,
    S_SCAN,
    S_RES
  } state_t;

  // input field split
  op_t                  in_op;
  logic [WAY_FLD_W-1:0] in_way;
  logic [NOW_W-1:0]     in_now;
  logic [31:0]          way_ext;
  logic                 in_set;
  logic [IDX_W-1:0]     way_idx;
  logic                 in_fire;

  assign in_op   = op_t'(in_tuser);
  assign in_way  = in_tdata[2:0];
  assign in_now  = in_tdata[34:3];
  assign way_ext = 32'(in_way);
  assign in_set  = (way_ext < WAYS);
  assign way_idx = way_ext[IDX_W-1:0];

  // control and captured transaction
  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [TIME_BITS-1:0]   time_r, time_nxt;
  logic                   set_r, set_nxt;
  logic                   is_victim_r, is_victim_nxt;
  logic [IDX_W:0]         scan_addr_r, scan_addr_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]       best_idx_r, best_idx_nxt;
  logic [COUNT_BITS-1:0]  best_cnt_r, best_cnt_nxt;
  logic [TIME_BITS-1:0]   best_time_r, best_time_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [7:0]             out_tdata_r, out_tdata_nxt;
  logic                   out_tuser_r, out_tuser_nxt;
  logic [WAYS-1:0]        valid_r, valid_nxt;

  // memory
  logic [WORD_W-1:0]      mem [WAYS];
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [WORD_W-1:0]      mem_wdata;
  logic [IDX_W-1:0]       mem_raddr;
  logic [WORD_W-1:0]      rd_word_r;
  logic                   rd_vld_r;

  // read data with invalid entries as zero
  logic [COUNT_BITS-1:0]  rd_cnt;
  logic [TIME_BITS-1:0]   rd_time;
  logic [COUNT_BITS-1:0]  cnt_inc;
  logic                   cmp_better;
  logic                   out_free;
  logic [31:0]            best_ext;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_tvalid_r | out_tready;

  assign rd_cnt  = rd_vld_r ? rd_word_r[COUNT_BITS-1:0] : '0;
  assign rd_time = rd_vld_r ? rd_word_r[WORD_W-1:COUNT_BITS] : '0;
  assign cnt_inc = (rd_cnt == {COUNT_BITS{1'b1}}) ? rd_cnt : rd_cnt + 1'b1;

  // shared comparator: lower count wins, older stamp breaks a count tie
  assign cmp_better = (rd_cnt < best_cnt_r) ||
                      ((rd_cnt == best_cnt_r) && (rd_time < best_time_r));

  assign best_ext = 32'(best_idx_r);

  always_comb begin
    if (state_r == S_IDLE) begin
      mem_raddr = (in_op == OP_VICTIM) ? '0 : way_idx;
    end else begin
      mem_raddr = scan_addr_r[IDX_W-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    time_nxt       = time_r;
    set_nxt        = set_r;
    is_victim_nxt  = is_victim_r;
    scan_addr_nxt  = scan_addr_r;
    cmp_idx_nxt    = cmp_idx_r;
    best_idx_nxt   = best_idx_r;
    best_cnt_nxt   = best_cnt_r;
    best_time_nxt  = best_time_r;
    valid_nxt      = valid_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = {time_r, cnt_inc};

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          idx_nxt       = way_idx;
          time_nxt      = TIME_BITS'(in_now);
          set_nxt       = in_set;
          is_victim_nxt = (in_op == OP_VICTIM);
          case (in_op)
            OP_INVALIDATE: begin
              if (in_set) begin
                valid_nxt[way_idx] = 1'b0;
              end
              state_nxt = S_RES;
            end
            OP_TOUCH: begin
              state_nxt = in_set ? S_TOUCH : S_RES;
            end
            OP_INSERT: begin
              if (in_set) begin
                mem_we             = 1'b1;
                mem_waddr          = way_idx;
                mem_wdata          = {TIME_BITS'(in_now), COUNT_BITS'(1)};
                valid_nxt[way_idx] = 1'b1;
              end
              state_nxt = S_RES;
            end
            OP_VICTIM: begin
              scan_addr_nxt = (IDX_W+1)'(1);
              cmp_idx_nxt   = '0;
              state_nxt     = S_SCAN;
            end
            default: begin
              state_nxt = S_RES;
            end
          endcase
        end
      end
      S_TOUCH: begin
        mem_we           = 1'b1;
        mem_waddr        = idx_r;
        mem_wdata        = {time_r, cnt_inc};
        valid_nxt[idx_r] = 1'b1;
        state_nxt        = S_RES;
      end
      S_SCAN: begin
        // first way seeds the running best
        if ((cmp_idx_r == '0) || cmp_better) begin
          best_idx_nxt  = cmp_idx_r;
          best_cnt_nxt  = rd_cnt;
          best_time_nxt = rd_time;
        end
        if (32'(cmp_idx_r) == WAYS - 1) begin
          state_nxt = S_RES;
        end else begin
          cmp_idx_nxt   = cmp_idx_r + 1'b1;
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = is_victim_r ? {5'd0, best_ext[2:0]} : 8'd0;
          out_tuser_nxt  = is_victim_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      valid_r      <= '0;
      scan_addr_r  <= '0;
      cmp_idx_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      valid_r      <= valid_nxt;
      scan_addr_r  <= scan_addr_nxt;
      cmp_idx_r    <= cmp_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    time_r      <= time_nxt;
    set_r       <= set_nxt;
    is_victim_r <= is_victim_nxt;
    best_idx_r  <= best_idx_nxt;
    best_cnt_r  <= best_cnt_nxt;
    best_time_r <= best_time_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_word_r <= mem[mem_raddr];
    rd_vld_r  <= valid_r[mem_raddr];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // read address runs one way ahead of the compared data
  a_scan_align: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> scan_addr_r == ({1'b0, cmp_idx_r} + 1'b1))
    else $error("scan read address out of step with compare index");

  a_victim_enters_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_op == OP_VICTIM |=> state_r == S_SCAN)
    else $error("victim request did not start a scan");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RES && out_free |=> out_tvalid_r && state_r == S_IDLE)
    else $error("finished transaction not moved to the result register");

  a_touch_out_of_set: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TOUCH |-> set_r)
    else $error("touch update for a way outside the set");

endmodule
